[src/sip_pkg.sv]
// shared types and constants for the sorted insert priority list
`timescale 1ns / 1ps

package sip_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic                     del;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

[src/sorted_insert_priority_list.sv]
// top level of the sorted insert priority list: cell chain, count and result register
`timescale 1ns / 1ps

//  channel | handshake              | fields
//  --------+------------------------+-------------------------------
//  in      | in_valid / in_stall    | op, value
//  out     | out_valid / out_stall  | ok, result_value, count
//
//  every item is applied to the whole cell chain at once, so one
//  item per cycle is taken while the result register is free or being read
//  the result appears in the cycle after its item is accepted
//  rst clears the entry count and the result valid; cell data is not reset
//  a stalled result blocks new items only while it is held in the register

module sorted_insert_priority_list #(
  parameter int unsigned CAPACITY = sip_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sip_pkg::OP_W-1:0]           op,
  input  logic signed [sip_pkg::DATA_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               ok,
  output logic signed [sip_pkg::DATA_W-1:0]  result_value,
  output logic [sip_pkg::COUNT_W-1:0]        count
);
  import sip_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // entry count doubles as the valid boundary of the chain
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  logic [EXT_W-1:0] count_ext;

  logic       accept;
  op_t        op_in;
  logic       full;
  logic       empty;
  logic       found;
  cmd_t       cmd;
  logic       ok_next;

  // per-cell links
  logic                     cell_valid [CAPACITY];
  logic                     cell_le    [CAPACITY];
  logic                     cell_hit   [CAPACITY];
  logic signed [DATA_W-1:0] cell_data  [CAPACITY];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op_in    = op_t'(op);

  assign full  = (entry_count == CNT_W'(CAPACITY));
  assign empty = (entry_count == '0);
  assign found = cell_hit[CAPACITY-1];

  // only successful operations touch the chain
  always_comb begin
    cmd.value = value;
    cmd.ins   = 1'b0;
    cmd.pop   = 1'b0;
    cmd.del   = 1'b0;
    ok_next   = 1'b0;
    unique case (op_in)
      OP_INSERT: begin
        cmd.ins = accept & ~full;
        ok_next = ~full;
      end
      OP_POP: begin
        cmd.pop = accept & ~empty;
        ok_next = ~empty;
      end
      OP_DELETE: begin
        cmd.del = accept & found;
        ok_next = found;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    entry_count_next = entry_count;
    if (cmd.ins) begin
      entry_count_next = entry_count + 1'b1;
    end else if (cmd.pop || cmd.del) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  // chain of cells: position 0 holds the smallest entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_le;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;
    logic                     hit_in;

    assign cell_valid[i] = (CNT_W'(i) < entry_count);

    if (i == 0) begin : g_first
      assign left_le   = 1'b1;
      assign left_data = value;
      assign hit_in    = 1'b0;
    end else begin : g_inner
      assign left_le   = cell_le[i-1];
      assign left_data = cell_data[i-1];
      assign hit_in    = cell_hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    sip_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (cell_valid[i]),
      .left_le    (left_le),
      .left_data  (left_data),
      .right_data (right_data),
      .hit_in     (hit_in),
      .le         (cell_le[i]),
      .hit_out    (cell_hit[i]),
      .data       (cell_data[i])
    );
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok           <= ok_next;
      result_value <= cmd.pop ? cell_data[0] : '0;
      count_ext    <= EXT_W'(entry_count_next);
    end
  end

  assign count = count_ext[COUNT_W-1:0];

`ifndef SYNTHESIS
  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a pop on a non-empty store removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    accept && op_in == OP_POP && !empty |=> entry_count == $past(entry_count) - 1'b1)
    else $error("pop did not remove one entry");

  // an insert into a full store reports failure and leaves the count alone
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    accept && op_in == OP_INSERT && full |=> !ok && entry_count == $past(entry_count))
    else $error("insert into full store accepted");
`endif

endmodule

[src/sip_cell.sv]
// one storage cell of the sorted chain
`timescale 1ns / 1ps

module sip_cell (
  input  logic                              clk,
  input  sip_pkg::cmd_t                     cmd,
  input  logic                              valid,
  input  logic                              left_le,
  input  logic signed [sip_pkg::DATA_W-1:0] left_data,
  input  logic signed [sip_pkg::DATA_W-1:0] right_data,
  input  logic                              hit_in,
  output logic                              le,
  output logic                              hit_out,
  output logic signed [sip_pkg::DATA_W-1:0] data
);
  import sip_pkg::*;

  logic                     eq;
  logic signed [DATA_W-1:0] data_next;

  assign le      = valid && (data <= cmd.value);
  assign eq      = valid && (data == cmd.value);
  assign hit_out = hit_in | eq;

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      // cells left of the slot keep, the slot takes the value, the rest shift right
      if (!le) begin
        data_next = left_le ? cmd.value : left_data;
      end
    end else if (cmd.pop) begin
      data_next = right_data;
    end else if (cmd.del) begin
      if (hit_out) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[bench/tb_sorted_insert_priority_list.sv]
// self-checking testbench for the sorted insert priority list
`timescale 1ns / 1ps

module tb_sorted_insert_priority_list;
  import sip_pkg::*;

  localparam int unsigned STORE_DEPTH = DEF_CAPACITY;

  // one expected result of the list
  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] removed;
    logic [COUNT_W-1:0]       entries;
  } list_outcome_t;

  // shadow copy of the sorted store plus the results still owed by the block
  class sip_scoreboard;
    logic signed [DATA_W-1:0] shadow_list[$];
    list_outcome_t            owed[$];
    int                       errors;

    function new();
      errors = 0;
    endfunction

    // apply one accepted item to the shadow store and queue its result
    function void note_item(op_t kind, logic signed [DATA_W-1:0] val);
      list_outcome_t exp_out;
      int            pos;
      exp_out.ok      = 1'b0;
      exp_out.removed = '0;
      case (kind)
        OP_INSERT: begin
          if (shadow_list.size() < STORE_DEPTH) begin
            // equal values go behind the ones already held
            pos = 0;
            while (pos < shadow_list.size() && shadow_list[pos] <= val) pos++;
            shadow_list.insert(pos, val);
            exp_out.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (shadow_list.size() > 0) begin
            exp_out.removed = shadow_list.pop_front();
            exp_out.ok      = 1'b1;
          end
        end
        OP_DELETE: begin
          for (pos = 0; pos < shadow_list.size(); pos++) begin
            if (shadow_list[pos] == val) begin
              shadow_list.delete(pos);
              exp_out.ok = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      exp_out.entries = COUNT_W'(shadow_list.size());
      owed.push_back(exp_out);
    endfunction

    // compare one accepted result with the oldest one owed
    function void check_result(logic got_ok, logic signed [DATA_W-1:0] got_val,
                               logic [COUNT_W-1:0] got_cnt);
      list_outcome_t exp_out;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result ok=%0b value=%0d count=%0d",
                 $time, got_ok, got_val, got_cnt);
        errors++;
        return;
      end
      exp_out = owed.pop_front();
      if (got_ok !== exp_out.ok) begin
        $display("%0t: ok mismatch, expected %0b actual %0b", $time, exp_out.ok, got_ok);
        errors++;
      end
      if (got_val !== exp_out.removed) begin
        $display("%0t: result_value mismatch, expected %0d actual %0d",
                 $time, exp_out.removed, got_val);
        errors++;
      end
      if (got_cnt !== exp_out.entries) begin
        $display("%0t: count mismatch, expected %0d actual %0d",
                 $time, exp_out.entries, got_cnt);
        errors++;
      end
    endfunction

    function int waiting();
      return owed.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     ok;
  logic signed [DATA_W-1:0] result_value;
  logic [COUNT_W-1:0]       count;

  sip_scoreboard sb = new();

  // idling switches, flipped per phase so some stretches run back to back
  bit                       feed_idles = 1'b1;
  bit                       drain_stalls = 1'b1;
  logic signed [DATA_W-1:0] pool[6];
  int                       sent;

  sorted_insert_priority_list DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .result_value (result_value),
    .count        (count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20ms;
    $display("sorted_insert_priority_list regression: fail");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // op mix per phase: 0 fills the store, 1 drains it, 2 keeps it mid-level
  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_NONE;
    case (mode)
      0:       return (r < 80) ? OP_INSERT : (r < 90) ? OP_POP : OP_DELETE;
      1:       return (r < 25) ? OP_INSERT : (r < 70) ? OP_POP : OP_DELETE;
      default: return (r < 45) ? OP_INSERT : (r < 70) ? OP_POP : OP_DELETE;
    endcase
  endfunction

  // pool values give duplicates and delete hits, raw values walk every bit
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return pool[$urandom_range(0, 5)];
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 6)) - 32'sd3;
      2:       return 32'sh8000_0000 + $urandom_range(0, 2);
      default: return 32'sh7fff_ffff - $urandom_range(0, 2);
    endcase
  endfunction

  // offer one item, called and returning at a falling edge
  task automatic push_item(input op_t kind, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = feed_idles ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op       <= kind;
    value    <= val;
    in_valid <= 1'b1;
    // item is taken at the first rising edge with in_stall low
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // receiver side: random stall bursts, switched off for whole phases
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (drain_stalls && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  // both handshakes are judged on values held just before the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(op_t'(op), value);
      if (out_valid && !out_stall) sb.check_result(ok, result_value, count);
    end
  end

  initial begin : stimulus
    int mode;
    int phase_len;
    int k;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_INSERT;
    value    = '0;
    sent     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty store failures, the unused code, extremes, equal values
    push_item(OP_POP, 32'sd0);
    push_item(OP_DELETE, 32'sd5);
    push_item(OP_NONE, 32'sd7);
    push_item(OP_INSERT, 32'sd0);
    push_item(OP_INSERT, 32'sh7fff_ffff);
    push_item(OP_INSERT, 32'sh8000_0000);
    push_item(OP_INSERT, -32'sd1);
    push_item(OP_INSERT, 32'sd0);
    push_item(OP_INSERT, 32'sd1);
    push_item(OP_DELETE, 32'sd0);
    push_item(OP_DELETE, 32'sd12345);
    push_item(OP_NONE, -32'sd1);
    push_item(OP_DELETE, 32'sh7fff_ffff);
    push_item(OP_POP, 32'sh5555_aaaa);
    push_item(OP_POP, 32'sd0);
    push_item(OP_POP, 32'sd0);
    push_item(OP_POP, 32'sd0);
    push_item(OP_POP, 32'sd0);
    push_item(OP_DELETE, 32'sh8000_0000);

    // random phases: fill to full, drain to empty, or churn in between
    sent = 0;
    while (sent < 1600) begin
      mode         = $urandom_range(0, 2);
      phase_len    = $urandom_range(20, 80);
      feed_idles   = ($urandom_range(0, 3) != 0);
      drain_stalls = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 6; k++) pool[k] = pool_value();
      for (k = 0; k < phase_len; k++) push_item(pick_op(mode), pick_value());
    end

    in_valid     <= 1'b0;
    drain_stalls  = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
    // leave room for any stray result
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("sorted_insert_priority_list regression: pass");
    end else begin
      $display("sorted_insert_priority_list regression: fail");
    end
    $finish;
  end

endmodule
